### hdl/ple_pkg.sv
// Shared constants and types for the prefixed line payload extractor.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ple_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] status_t;

	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_LEAD  = 8'h10;
	localparam byte_t CH_G     = 8'h47;
	localparam byte_t CH_B     = 8'h42;
	localparam byte_t CH_OPEN  = 8'h28;
	localparam byte_t CH_CLOSE = 8'h29;
	localparam int    MIN_FRAME = 5;
	localparam int    PREFIX_LEN = 3;

	localparam status_t ST_PAYLOAD   = 3'd0;
	localparam status_t ST_EMPTY     = 3'd1;
	localparam status_t ST_PREFIX    = 3'd2;
	localparam status_t ST_MALFORMED = 3'd3;
	localparam status_t ST_OVERFLOW  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    store;      // write the input byte into the line store
		logic    clear;      // empty the line and its tracking registers
		logic    run_start;  // latch the payload read window of the current line
		logic    rd_issue;   // read the line store at the read pointer
		logic    out_load;   // load the output register
		logic    out_mem;    // output byte comes from the read data
		logic    out_last;
		status_t out_status;
	} ple_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    is_cr;
		logic    is_lf;
		logic    full;       // fill count at LINE_DEPTH - 1, the most bytes a line may hold
		status_t verdict;    // judgment of the stored line
		logic    rd_last;    // read data holds the last payload byte
	} ple_sts_t;

endpackage

### hdl/ple_rx_if.sv
// Input channel of the extractor: one received byte per item.
// Depends on ple_pkg for the byte type.
interface ple_rx_if;
	logic           valid;
	logic           ready;
	ple_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/ple_res_if.sv
// Result channel of the extractor: payload byte, end-of-run flag and status.
// Depends on ple_pkg for the byte and status types.
interface ple_res_if;
	logic             valid;
	logic             ready;
	ple_pkg::byte_t   payload_byte;
	logic             run_last;
	ple_pkg::status_t frame_status;

	modport source (output valid, output payload_byte, output run_last,
		output frame_status, input ready);
	modport sink (input valid, input payload_byte, input run_last,
		input frame_status, output ready);
endinterface

### hdl/ple_dp.sv
// Datapath of the extractor: line store memory, fill count, line tracking,
// read window and output register. Depends on ple_pkg.
module ple_dp #(
	parameter int LINE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::byte_t    in_byte,
	input  ple_pkg::ple_cmd_t cmd,
	output ple_pkg::ple_sts_t sts,
	output ple_pkg::byte_t    payload_byte,
	output logic              run_last,
	output ple_pkg::status_t  frame_status
);

	localparam int AW = $clog2(LINE_DEPTH);

	ple_pkg::byte_t line_store [LINE_DEPTH];

	logic [AW-1:0]  count_q;
	logic           zero_seen_q;
	logic [AW-1:0]  zpos_q;
	ple_pkg::byte_t tail_q;
	ple_pkg::byte_t head_q [4];

	logic [AW-1:0]  rd_ptr_q;
	logic [AW-1:0]  end_ptr_q;
	ple_pkg::byte_t rd_data_q;
	logic           rd_last_q;

	ple_pkg::byte_t   out_byte_q;
	logic             out_last_q;
	ple_pkg::status_t out_status_q;

	logic [AW-1:0] line_end;
	logic          lead;
	logic [AW-1:0] line_len;
	logic          prefix_ok;

	// The line is judged up to its first zero byte; the tracking registers
	// follow that boundary as bytes are stored, so no scan is needed.
	always_comb begin
		line_end = zero_seen_q ? zpos_q : count_q;
		lead     = (head_q[0] == ple_pkg::CH_LEAD);
		line_len = line_end - AW'(lead);
		if (lead) begin
			prefix_ok = (head_q[1] == ple_pkg::CH_G) && (head_q[2] == ple_pkg::CH_B) &&
				(head_q[3] == ple_pkg::CH_OPEN);
		end else begin
			prefix_ok = (head_q[0] == ple_pkg::CH_G) && (head_q[1] == ple_pkg::CH_B) &&
				(head_q[2] == ple_pkg::CH_OPEN);
		end
		if (line_end == '0) begin
			sts.verdict = ple_pkg::ST_EMPTY;
		end else if (line_len < AW'(ple_pkg::PREFIX_LEN) || !prefix_ok) begin
			sts.verdict = ple_pkg::ST_PREFIX;
		end else if (line_len < AW'(ple_pkg::MIN_FRAME) || tail_q != ple_pkg::CH_CLOSE) begin
			sts.verdict = ple_pkg::ST_MALFORMED;
		end else begin
			sts.verdict = ple_pkg::ST_PAYLOAD;
		end
		sts.is_cr   = (in_byte == ple_pkg::CH_CR);
		sts.is_lf   = (in_byte == ple_pkg::CH_LF);
		sts.full    = (count_q >= AW'(LINE_DEPTH - 1));
		sts.rd_last = rd_last_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			line_store[count_q] <= in_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= line_store[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			zero_seen_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q     <= '0;
			zero_seen_q <= 1'b0;
		end else if (cmd.store) begin
			count_q <= count_q + AW'(1);
			if (!zero_seen_q && in_byte == '0) begin
				zero_seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (count_q[AW-1:2] == '0) begin
				head_q[count_q[1:0]] <= in_byte;
			end
			if (!zero_seen_q) begin
				if (in_byte == '0) begin
					zpos_q <= count_q;
				end else begin
					tail_q <= in_byte;
				end
			end
		end
		if (cmd.run_start) begin
			rd_ptr_q  <= AW'(lead) + AW'(ple_pkg::PREFIX_LEN);
			end_ptr_q <= line_end - AW'(2);
		end else if (cmd.rd_issue) begin
			rd_ptr_q  <= rd_ptr_q + AW'(1);
			rd_last_q <= (rd_ptr_q == end_ptr_q);
		end
		if (cmd.out_load) begin
			out_byte_q   <= cmd.out_mem ? rd_data_q : '0;
			out_last_q   <= cmd.out_last;
			out_status_q <= cmd.out_status;
		end
	end

	assign payload_byte = out_byte_q;
	assign run_last     = out_last_q;
	assign frame_status = out_status_q;

endmodule

### hdl/ple_ctrl.sv
// Controller of the extractor: decodes accepted bytes, sequences the payload
// read-out and owns the handshakes. Depends on ple_pkg.
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ple_pkg::ple_sts_t sts,
	output ple_pkg::ple_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SEND = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       in_fire;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && !sts.is_cr) begin
					if (sts.is_lf) begin
						cmd.clear = 1'b1;
						if (sts.verdict == ple_pkg::ST_PAYLOAD) begin
							cmd.run_start = 1'b1;
							state_d       = S_READ;
						end else begin
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = sts.verdict;
						end
					end else if (sts.full) begin
						cmd.clear      = 1'b1;
						cmd.out_load   = 1'b1;
						cmd.out_status = ple_pkg::ST_OVERFLOW;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_SEND;
			end
			S_SEND: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_mem    = 1'b1;
					cmd.out_last   = sts.rd_last;
					cmd.out_status = ple_pkg::ST_PAYLOAD;
					state_d        = sts.rd_last ? S_IDLE : S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new result must never overwrite one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while still pending");

	a_read_then_send: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_SEND)
		else $error("read not followed by send");

	a_run_on_lf: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_start |-> (in_fire && sts.is_lf && sts.verdict == ple_pkg::ST_PAYLOAD))
		else $error("payload run started without a valid line feed");

	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.store && (cmd.clear || cmd.out_load)))
		else $error("byte stored together with a clear or a result");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEND && cmd.out_load && cmd.out_last) |=> state_q == S_IDLE)
		else $error("run continued after its last item");

endmodule

### hdl/prefixed_line_payload_extractor.sv
// Top level of the prefixed line payload extractor: channels, controller and
// datapath. Depends on ple_pkg, ple_rx_if, ple_res_if, ple_ctrl and ple_dp.
//
//   channel | dir | fields                                  | item
//   rx      | in  | rx_byte[7:0]                            | one received byte
//   res     | out | payload_byte[7:0] run_last frame_status | one result
//
// Stored bytes, dropped carriage returns and status results complete on acceptance.
// A valid line gives its payload byte by byte: each byte is read into a register and
// loaded into the output register before the next byte of the line store is read.
// No item is taken while a payload run is read out or while a result is stalled.
// Reset clears the fill count, the zero-byte flag and control state only; the line store is not swept.
module prefixed_line_payload_extractor #(
	parameter int LINE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	ple_rx_if.sink     rx,
	ple_res_if.source  res
);

	ple_pkg::ple_cmd_t cmd;
	ple_pkg::ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (rx.rx_byte),
		.cmd          (cmd),
		.sts          (sts),
		.payload_byte (res.payload_byte),
		.run_last     (res.run_last),
		.frame_status (res.frame_status)
	);

endmodule
